### design/bpst_pkg.sv
// ----------------------------------------------------------------------------
// Bias predictor SGD trainer package
// Shared constants, codes and types for the bias predictor trainer.
// ----------------------------------------------------------------------------
package bpst_pkg;

   // Table depths and the address widths derived from them.
   localparam int USER_COUNT  = 4096;
   localparam int ITEM_COUNT  = 4096;
   localparam int USER_ADDR_W = $clog2(USER_COUNT);
   localparam int ITEM_ADDR_W = $clog2(ITEM_COUNT);
   localparam int CLEAR_DEPTH = (USER_COUNT > ITEM_COUNT) ? USER_COUNT : ITEM_COUNT;
   localparam int CLEAR_W     = $clog2(CLEAR_DEPTH);

   // Field widths.
   localparam int INDEX_W  = 12;
   localparam int RATING_W = 3;
   localparam int BIAS_W   = 18;
   localparam int MEAN_W   = 15;
   localparam int RATE_W   = 16;
   localparam int ERR_W    = 16;
   localparam int SQ_W     = 29;
   localparam int GRAD_W   = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 96;

   // Register reset values.
   localparam logic [MEAN_W-1:0] MEAN_RESET  = 15'd14746;
   localparam logic [RATE_W-1:0] ALPHA_RESET = 16'd655;
   localparam logic [RATE_W-1:0] BETA_RESET  = 16'd3277;

   // Prediction clamp bounds in Q3.12.
   localparam logic signed [19:0] PRED_LO = 20'sd4096;
   localparam logic signed [19:0] PRED_HI = 20'sd20480;

   // Saturation bounds of a bias.
   localparam logic signed [20:0] BIAS_MAX = 21'sd131071;
   localparam logic signed [20:0] BIAS_MIN = -21'sd131072;

   typedef enum logic [1:0] {
      OP_TRAIN      = 2'd0,
      OP_PREDICT    = 2'd1,
      OP_WRITE_USER = 2'd2,
      OP_WRITE_ITEM = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOBAL_MEAN    = 2'd0,
      CSR_LEARNING_RATE  = 2'd1,
      CSR_REGULARIZATION = 2'd2,
      CSR_UPDATE_ENABLE  = 2'd3
   } csr_index_type;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_PRED   = 6'b000100,
      S_SHRINK = 6'b001000,
      S_STEP   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // Stage strobes for the bias update datapath.
   typedef struct packed {
      logic load_grad;
      logic load_prod;
   } step_ctrl_type;

endpackage

### design/bias_predictor_sgd_trainer_unit.sv
// ----------------------------------------------------------------------------
// Bias predictor SGD trainer
// User and item bias tables with prediction, error and a regularized update.
// ----------------------------------------------------------------------------
// An accepted item passes S_PRED, S_SHRINK, S_STEP and S_FINISH; rsp_tvalid
// rises as it leaves S_FINISH, which it holds while an earlier result still
// waits in the output register. An item is read from the bias memories, passes
// the prediction and the two-multiply update chain and is written back before
// the next item is taken.
// Reset: synchronous; afterwards both tables are zeroed by a clearing pass
// (one entry per cycle) while req_tready stays low.
module bias_predictor_sgd_trainer_unit
   import bpst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,  // operation
   // user_index, item_index, rating_value, bias_value, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // prediction, error, squared_error, user_bias_out, item_bias_out
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;
   logic [CLEAR_W-1:0] clr_cnt_ff;

   logic [MEAN_W-1:0] mean_ff;
   logic [RATE_W-1:0] alpha_ff;
   logic [RATE_W-1:0] beta_ff;
   logic              upd_en_ff;

   op_type                   op_ff;
   logic [INDEX_W-1:0]       uidx_ff;
   logic [INDEX_W-1:0]       iidx_ff;
   logic [RATING_W-1:0]      rating_ff;
   logic signed [BIAS_W-1:0] wval_ff;
   logic                     uok_ff;
   logic                     iok_ff;

   logic signed [BIAS_W-1:0] bu_ff, bi_ff;
   logic signed [BIAS_W-1:0] bu_in, bi_in;
   logic [MEAN_W-1:0]        pred_ff, pred_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [31:0]       sq_full;

   logic signed [19:0]   pred_sum;
   logic [RATING_W-1:0]  rating_c;
   logic signed [16:0]   err_wide;

   logic                 rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic req_accept;
   logic out_free;
   logic finish_go;
   logic train_upd;

   logic                   user_we, item_we;
   logic [USER_ADDR_W-1:0] user_waddr, user_raddr;
   logic [ITEM_ADDR_W-1:0] item_waddr, item_raddr;
   logic [BIAS_W-1:0]      user_wdata, item_wdata;
   logic [BIAS_W-1:0]      user_rdata, item_rdata;

   step_ctrl_type            step_ctrl;
   logic signed [BIAS_W-1:0] bu_new, bi_new;
   logic signed [BIAS_W-1:0] bu_out, bi_out;
   logic [MEAN_W-1:0]        pred_out;
   logic [ERR_W-1:0]         err_out;
   logic [SQ_W-1:0]          sq_out;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign finish_go  = (state_ff == S_FINISH) && out_free;
   assign train_upd  = (op_ff == OP_TRAIN) && upd_en_ff;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff   <= MEAN_RESET;
         alpha_ff  <= ALPHA_RESET;
         beta_ff   <= BETA_RESET;
         upd_en_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GLOBAL_MEAN:    mean_ff   <= csr_wdata[MEAN_W-1:0];
            CSR_LEARNING_RATE:  alpha_ff  <= csr_wdata;
            CSR_REGULARIZATION: beta_ff   <= csr_wdata;
            CSR_UPDATE_ENABLE:  upd_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (32'(clr_cnt_ff) == CLEAR_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_PRED;
            end
         end
         S_PRED:   state_in = S_SHRINK;
         S_SHRINK: state_in = S_STEP;
         S_STEP:   state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (finish_go) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Input capture; the memories are read at the same edge.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= op_type'(req_tuser);
         uidx_ff   <= req_tdata[11:0];
         iidx_ff   <= req_tdata[23:12];
         rating_ff <= req_tdata[26:24];
         wval_ff   <= $signed(req_tdata[44:27]);
         uok_ff    <= 32'(req_tdata[11:0]) < USER_COUNT;
         iok_ff    <= 32'(req_tdata[23:12]) < ITEM_COUNT;
      end
   end

   assign user_raddr = USER_ADDR_W'(req_tdata[11:0]);
   assign item_raddr = ITEM_ADDR_W'(req_tdata[23:12]);

   // Prediction and error from the biases read for this item. An index
   // beyond the table depth reads as zero.
   assign bu_in    = uok_ff ? $signed(user_rdata) : '0;
   assign bi_in    = iok_ff ? $signed(item_rdata) : '0;
   assign pred_sum = $signed({5'b0, mean_ff}) + 20'(bu_in) + 20'(bi_in);

   always_comb begin
      if (pred_sum < PRED_LO) begin
         pred_in = PRED_LO[MEAN_W-1:0];
      end else if (pred_sum > PRED_HI) begin
         pred_in = PRED_HI[MEAN_W-1:0];
      end else begin
         pred_in = pred_sum[MEAN_W-1:0];
      end
      if (rating_ff == 3'd0) begin
         rating_c = 3'd1;
      end else if (rating_ff > 3'd5) begin
         rating_c = 3'd5;
      end else begin
         rating_c = rating_ff;
      end
   end

   assign err_wide = $signed({2'b0, rating_c, 12'b0}) - $signed({2'b0, pred_in});
   assign err_in   = err_wide[ERR_W-1:0];
   assign sq_full  = err_ff * err_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_PRED) begin
         bu_ff   <= bu_in;
         bi_ff   <= bi_in;
         pred_ff <= pred_in;
         err_ff  <= err_in;
      end
      if (state_ff == S_SHRINK) begin
         sq_ff <= sq_full[SQ_W-1:0];
      end
   end

   assign step_ctrl.load_grad = (state_ff == S_SHRINK);
   assign step_ctrl.load_prod = (state_ff == S_STEP);

   bpst_bias_step u_user_step (
      .clock    (clock),
      .ctrl     (step_ctrl),
      .bias     (bu_ff),
      .err      (err_ff),
      .alpha    (alpha_ff),
      .beta     (beta_ff),
      .bias_new (bu_new)
   );

   bpst_bias_step u_item_step (
      .clock    (clock),
      .ctrl     (step_ctrl),
      .bias     (bi_ff),
      .err      (err_ff),
      .alpha    (alpha_ff),
      .beta     (beta_ff),
      .bias_new (bi_new)
   );

   // Result fields and write-back values.
   always_comb begin
      if (!uok_ff) begin
         bu_out = '0;
      end else if (op_ff == OP_WRITE_USER) begin
         bu_out = wval_ff;
      end else if (train_upd) begin
         bu_out = bu_new;
      end else begin
         bu_out = bu_ff;
      end
      if (!iok_ff) begin
         bi_out = '0;
      end else if (op_ff == OP_WRITE_ITEM) begin
         bi_out = wval_ff;
      end else if (train_upd) begin
         bi_out = bi_new;
      end else begin
         bi_out = bi_ff;
      end
      if (op_ff == OP_WRITE_USER || op_ff == OP_WRITE_ITEM) begin
         pred_out = '0;
         err_out  = '0;
         sq_out   = '0;
      end else begin
         pred_out = pred_ff;
         err_out  = err_ff;
         sq_out   = sq_ff;
      end
   end

   assign rsp_tdata_in = {bi_out, bu_out, sq_out, err_out, pred_out};

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // Memory writes: zeroing sweep after reset, then at most one write-back per table per item.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         user_we    = 32'(clr_cnt_ff) < USER_COUNT;
         item_we    = 32'(clr_cnt_ff) < ITEM_COUNT;
         user_waddr = USER_ADDR_W'(clr_cnt_ff);
         item_waddr = ITEM_ADDR_W'(clr_cnt_ff);
         user_wdata = '0;
         item_wdata = '0;
      end else begin
         user_we    = finish_go && uok_ff && (op_ff == OP_WRITE_USER || train_upd);
         item_we    = finish_go && iok_ff && (op_ff == OP_WRITE_ITEM || train_upd);
         user_waddr = USER_ADDR_W'(uidx_ff);
         item_waddr = ITEM_ADDR_W'(iidx_ff);
         user_wdata = bu_out;
         item_wdata = bi_out;
      end
   end

   bpst_ram #(
      .WIDTH (BIAS_W),
      .DEPTH (USER_COUNT)
   ) u_user_ram (
      .clock   (clock),
      .wr_en   (user_we),
      .wr_addr (user_waddr),
      .wr_data (user_wdata),
      .rd_addr (user_raddr),
      .rd_data (user_rdata)
   );

   bpst_ram #(
      .WIDTH (BIAS_W),
      .DEPTH (ITEM_COUNT)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_waddr),
      .wr_data (item_wdata),
      .rd_addr (item_raddr),
      .rd_data (item_rdata)
   );

   // No item is taken while the tables are being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("item accepted during table clearing");

   // An accepted item always moves on to the prediction stage.
   a_accept_to_pred: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_PRED))
      else $error("accepted item did not enter prediction");

   // A predict item never modifies either table.
   a_predict_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR && op_ff == OP_PREDICT) |-> !(user_we || item_we))
      else $error("predict item wrote a bias table");

   // A new result is only presented when an item leaves the last stage.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside the finish stage");

   // Memory writes outside the clearing pass happen only when a result is loaded.
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR && (user_we || item_we)) |=> rsp_tvalid_ff)
      else $error("table write-back without a result");

endmodule

### design/bpst_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpst_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### design/bpst_bias_step.sv
// ----------------------------------------------------------------------------
// Bias update step
// Regularized gradient step b + alpha * (e - beta * b), rounded and saturated.
// ----------------------------------------------------------------------------
module bpst_bias_step
   import bpst_pkg::*;
(
   input  logic                     clock,
   input  step_ctrl_type            ctrl,
   input  logic signed [BIAS_W-1:0] bias,
   input  logic signed [ERR_W-1:0]  err,
   input  logic [RATE_W-1:0]        alpha,
   input  logic [RATE_W-1:0]        beta,
   output logic signed [BIAS_W-1:0] bias_new
);

   logic signed [34:0]       shrink_prod;
   logic signed [34:0]       shrink_sum;
   logic signed [GRAD_W-1:0] shrink_round;
   logic signed [GRAD_W-1:0] grad_in;
   logic signed [GRAD_W-1:0] grad_ff;
   logic signed [35:0]       prod_in;
   logic signed [35:0]       prod_ff;
   logic signed [35:0]       prod_sum;
   logic signed [20:0]       sum;

   // Products are scaled by 2^-16 and rounded half up, which is the
   // floor of the product plus one half.
   assign shrink_prod  = $signed({1'b0, beta}) * bias;
   assign shrink_sum   = shrink_prod + 35'sd32768;
   assign shrink_round = shrink_sum[34:16];
   assign grad_in      = GRAD_W'(err) - shrink_round;

   assign prod_in  = $signed({1'b0, alpha}) * grad_ff;
   assign prod_sum = prod_ff + 36'sd32768;
   assign sum      = 21'(bias) + 21'($signed(prod_sum[35:16]));

   always_ff @(posedge clock) begin
      if (ctrl.load_grad) begin
         grad_ff <= grad_in;
      end
      if (ctrl.load_prod) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      if (sum > BIAS_MAX) begin
         bias_new = BIAS_MAX[BIAS_W-1:0];
      end else if (sum < BIAS_MIN) begin
         bias_new = BIAS_MIN[BIAS_W-1:0];
      end else begin
         bias_new = sum[BIAS_W-1:0];
      end
   end

endmodule

### bench/bias_predictor_sgd_trainer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias predictor SGD trainer checker
// Watches the rating, result and register ports, keeps its own copy of the
// two bias tables and the registers, predicts every result and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module bias_predictor_sgd_trainer_checker
   import bpst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    outstanding,
   output int                    compared
);

   typedef struct packed {
      logic        [MEAN_W-1:0] prediction;
      logic signed [ERR_W-1:0]  error;
      logic        [SQ_W-1:0]   squared_error;
      logic signed [BIAS_W-1:0] user_bias;
      logic signed [BIAS_W-1:0] item_bias;
   } rating_result_type;

   logic signed [BIAS_W-1:0] user_bias_q12 [USER_COUNT];
   logic signed [BIAS_W-1:0] item_bias_q12 [ITEM_COUNT];
   logic        [MEAN_W-1:0] mean_q12;
   logic        [RATE_W-1:0] alpha_q16;
   logic        [RATE_W-1:0] beta_q16;
   logic                     update_enable;

   rating_result_type expected_results [$];
   rating_result_type want;

   // One regularized gradient step; products with alpha and beta are
   // rounded half up before they are added.
   function automatic logic signed [BIAS_W-1:0] sgd_step(input longint b, input longint e);
      longint shrink;
      longint nb;
      shrink = (longint'(beta_q16) * b + 32768) >>> 16;
      nb = b + ((longint'(alpha_q16) * (e - shrink) + 32768) >>> 16);
      if (nb > BIAS_MAX) nb = BIAS_MAX;
      if (nb < BIAS_MIN) nb = BIAS_MIN;
      return nb[BIAS_W-1:0];
   endfunction

   function automatic rating_result_type score_rating(input op_type op,
                                                   input logic [INDEX_W-1:0] user,
                                                   input logic [INDEX_W-1:0] item,
                                                   input logic [RATING_W-1:0] stars,
                                                   input logic signed [BIAS_W-1:0] load_value);
      rating_result_type res;
      longint bu;
      longint bi;
      longint guess;
      longint miss;
      longint square;
      longint clamped_stars;
      res = '0;
      case (op)
         OP_WRITE_USER: user_bias_q12[user] = load_value;
         OP_WRITE_ITEM: item_bias_q12[item] = load_value;
         default: begin
            bu = user_bias_q12[user];
            bi = item_bias_q12[item];
            guess = longint'(mean_q12) + bu + bi;
            if (guess < PRED_LO) guess = PRED_LO;
            if (guess > PRED_HI) guess = PRED_HI;
            clamped_stars = stars;
            if (clamped_stars < 1) clamped_stars = 1;
            if (clamped_stars > 5) clamped_stars = 5;
            // The integer rating becomes Q3.12 before the subtraction.
            miss = (clamped_stars <<< 12) - guess;
            square = miss * miss;
            res.prediction    = guess[MEAN_W-1:0];
            res.error         = miss[ERR_W-1:0];
            res.squared_error = square[SQ_W-1:0];
            // Both steps use the error from the biases read before the update.
            if (op == OP_TRAIN && update_enable) begin
               user_bias_q12[user] = sgd_step(bu, miss);
               item_bias_q12[item] = sgd_step(bi, miss);
            end
         end
      endcase
      res.user_bias = user_bias_q12[user];
      res.item_bias = item_bias_q12[item];
      return res;
   endfunction

   task automatic check_field(input string field, input longint expected, input longint actual);
      if (expected != actual) begin
         $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < USER_COUNT; k++) user_bias_q12[k] = '0;
         for (int k = 0; k < ITEM_COUNT; k++) item_bias_q12[k] = '0;
         mean_q12      = MEAN_RESET;
         alpha_q16     = ALPHA_RESET;
         beta_q16      = BETA_RESET;
         update_enable = 1'b1;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_GLOBAL_MEAN:    mean_q12      = csr_wdata[MEAN_W-1:0];
               CSR_LEARNING_RATE:  alpha_q16     = csr_wdata[RATE_W-1:0];
               CSR_REGULARIZATION: beta_q16      = csr_wdata[RATE_W-1:0];
               CSR_UPDATE_ENABLE:  update_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(score_rating(op_type'(req_tuser),
                                                    req_tdata[11:0], req_tdata[23:12],
                                                    req_tdata[26:24], req_tdata[44:27]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("Result item arrived with no rating item outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               compared++;
               check_field("prediction", want.prediction, rsp_tdata[14:0]);
               check_field("error", want.error, $signed(rsp_tdata[30:15]));
               check_field("squared_error", want.squared_error, rsp_tdata[59:31]);
               check_field("user_bias_out", want.user_bias, $signed(rsp_tdata[77:60]));
               check_field("item_bias_out", want.item_bias, $signed(rsp_tdata[95:78]));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

### bench/bias_predictor_sgd_trainer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bias predictor SGD trainer testbench
// Drives directed corner cases and about 1200 random rating items through
// the trainer under several register settings, with random idling on both
// sides and one long receiver stall; a checker module predicts every result.
// ----------------------------------------------------------------------------
module bias_predictor_sgd_trainer_unit_test;
   import bpst_pkg::*;

   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int PHASE_ITEMS   = 200;
   localparam int HOLD_CYCLES   = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;  // operation
   // user_index, item_index, rating_value, bias_value, zero pad
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // prediction, error, squared_error, user_bias_out, item_bias_out
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int failures;
   int outstanding;
   int compared;
   int op_count [4];
   int settings_used;
   int quiet_cycles;
   bit steady;
   bit hold_asked;
   bit hold_done;

   bias_predictor_sgd_trainer_unit dut (.*);

   bias_predictor_sgd_trainer_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Offers one rating item, with a random gap first unless idling is off.
   task automatic offer_rating(input op_type op, input logic [INDEX_W-1:0] user,
                               input logic [INDEX_W-1:0] item,
                               input logic [RATING_W-1:0] stars,
                               input logic [BIAS_W-1:0] load_value);
      if (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, load_value, stars, item, user};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      op_count[op]++;
      @(negedge clock);
   endtask

   // Waits until the block is idle, then writes all four registers.
   task automatic apply_settings(input logic [MEAN_W-1:0] mean, input logic [RATE_W-1:0] alpha,
                                 input logic [RATE_W-1:0] beta, input logic enable);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_GLOBAL_MEAN;
      csr_wdata <= CSR_DATA_W'(mean);
      @(negedge clock);
      csr_index <= CSR_LEARNING_RATE;
      csr_wdata <= alpha;
      @(negedge clock);
      csr_index <= CSR_REGULARIZATION;
      csr_wdata <= beta;
      @(negedge clock);
      csr_index <= CSR_UPDATE_ENABLE;
      csr_wdata <= CSR_DATA_W'(enable);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Receiver: random back-pressure, one long hold when the sender asks.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 35);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a handshake", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int kind;
      op_type op;
      logic [INDEX_W-1:0] user;
      logic [INDEX_W-1:0] item;
      logic [RATING_W-1:0] stars;
      logic [BIAS_W-1:0] load_value;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = '0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      settings_used = 1;
      steady        = 1'b0;
      hold_asked    = 1'b0;
      foreach (op_count[k]) op_count[k] = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Reset settings: zero tables and every rating code, clamped or not.
      for (int r = 0; r < 8; r++) begin
         offer_rating((r % 2 == 0) ? OP_TRAIN : OP_PREDICT, 12'd0, 12'd0, RATING_W'(r),
                      18'h3FFFF);
      end
      offer_rating(OP_WRITE_USER, 12'd4095, 12'd0, 3'd1, 18'sd131071);
      offer_rating(OP_WRITE_ITEM, 12'd0, 12'd4095, 3'd1, -18'sd131072);
      offer_rating(OP_PREDICT, 12'd4095, 12'd4095, 3'd5, 18'd0);

      // Full step size, no shrink: drive each bias into saturation.
      apply_settings(15'd20480, 16'hFFFF, 16'h0000, 1'b1);
      offer_rating(OP_WRITE_USER, 12'd2, 12'd2, 3'd3, 18'sd131071);
      offer_rating(OP_WRITE_ITEM, 12'd2, 12'd2, 3'd3, -18'sd131072);
      offer_rating(OP_TRAIN, 12'd2, 12'd2, 3'd5, 18'd0);
      offer_rating(OP_WRITE_USER, 12'd3, 12'd3, 3'd3, -18'sd131072);
      offer_rating(OP_WRITE_ITEM, 12'd3, 12'd3, 3'd3, 18'sd131071);
      offer_rating(OP_TRAIN, 12'd3, 12'd3, 3'd1, 18'd0);

      // Updates frozen, lowest mean.
      apply_settings(15'd4096, 16'hFFFF, 16'hFFFF, 1'b0);
      offer_rating(OP_TRAIN, 12'd2, 12'd2, 3'd7, 18'd0);
      offer_rating(OP_PREDICT, 12'd0, 12'd4095, 3'd0, 18'd0);
      apply_settings(15'd4096, 16'hFFFF, 16'hFFFF, 1'b1);
      offer_rating(OP_TRAIN, 12'd4095, 12'd4095, 3'd2, 18'd0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            case (n / PHASE_ITEMS)
               0: apply_settings(15'd14746, RATE_W'($urandom_range(3000, 200)),
                                 RATE_W'($urandom_range(4000)), 1'b1);
               1: apply_settings(15'd4096, 16'hFFFF, 16'hFFFF, 1'b1);
               2: apply_settings(15'd20480, 16'h0000, RATE_W'($urandom), 1'b1);
               3: apply_settings(MEAN_W'($urandom_range(20480, 4096)), RATE_W'($urandom),
                                 RATE_W'($urandom), 1'b0);
               4: apply_settings(MEAN_W'($urandom_range(20480, 4096)),
                                 RATE_W'($urandom_range(8000, 100)),
                                 RATE_W'($urandom_range(20000)), 1'b1);
               default: apply_settings(MEAN_W'($urandom_range(20480, 4096)),
                                       RATE_W'($urandom), 16'h0000, 1'b1);
            endcase
         end
         steady = (n >= 400 && n < 600);
         if (n == 800) hold_asked = 1'b1;

         kind = $urandom_range(99);
         if (kind < 50) op = OP_TRAIN;
         else if (kind < 70) op = OP_PREDICT;
         else if (kind < 85) op = OP_WRITE_USER;
         else op = OP_WRITE_ITEM;
         // A small set of hot indexes keeps the biases moving; the rest span the table.
         user = INDEX_W'(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(15));
         item = INDEX_W'(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(15));
         stars = RATING_W'(($urandom_range(9) == 0) ? $urandom_range(7)
                                                    : $urandom_range(5, 1));
         load_value = BIAS_W'(($urandom_range(3) == 0) ? $urandom
                                                       : ($urandom_range(16383) - 8192));
         offer_rating(op, user, item, stars, load_value);
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d train, %0d predict, %0d user-write and %0d item-write items",
               op_count[OP_TRAIN], op_count[OP_PREDICT],
               op_count[OP_WRITE_USER], op_count[OP_WRITE_ITEM]);
      $display("over %0d register settings; %0d result items compared.",
               settings_used, compared);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
